@@ src/elt_pkg.sv @@
// shared types, character codes and helper functions of the expression language tokenizer
package elt_pkg;

   // token kinds as they leave the block
   typedef enum logic [3:0] {
      KIND_END     = 4'd0,
      KIND_PLUS    = 4'd1,
      KIND_MINUS   = 4'd2,
      KIND_STAR    = 4'd3,
      KIND_SLASH   = 4'd4,
      KIND_LPAREN  = 4'd5,
      KIND_RPAREN  = 4'd6,
      KIND_SEMI    = 4'd7,
      KIND_PRINT   = 4'd8,
      KIND_NUMBER  = 4'd9,
      KIND_INVALID = 4'd10
   } kind_type;

   // scanner modes, one-hot
   typedef enum logic [5:0] {
      MODE_IDLE    = 6'b000001,
      MODE_WORD    = 6'b000010,
      MODE_NUM     = 6'b000100,
      MODE_SLASH   = 6'b001000,
      MODE_COMMENT = 6'b010000,
      MODE_DONE    = 6'b100000
   } mode_type;

   localparam int          VALUE_BITS = 31;
   localparam int          POS_OUT_BITS = 16;
   localparam int          MAX_TOKENS = 3;
   localparam logic [2:0]  KW_LENGTH = 3'd5;
   localparam logic [34:0] VALUE_MAX = 35'h7FFF_FFFF;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   // one token on its way out
   typedef struct packed {
      kind_type                  kind;
      logic [VALUE_BITS-1:0]     value;
      logic [POS_OUT_BITS-1:0]   line;
      logic [POS_OUT_BITS-1:0]   column;
   } token_type;

   // all tokens caused by one byte
   typedef struct packed {
      token_type [MAX_TOKENS-1:0] slot;
      logic [1:0]                 count;
   } bundle_type;

   // token that a pending word, number or slash turns into
   typedef struct packed {
      logic                  valid;
      kind_type              kind;
      logic [VALUE_BITS-1:0] value;
   } pend_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   // letters of the keyword print
   function automatic logic [7:0] kw_char(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0: r = 8'h70;
         3'd1: r = 8'h72;
         3'd2: r = 8'h69;
         3'd3: r = 8'h6E;
         3'd4: r = 8'h74;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // single-character operator kinds
   function automatic kind_type op_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         CH_PLUS:   k = KIND_PLUS;
         CH_MINUS:  k = KIND_MINUS;
         CH_STAR:   k = KIND_STAR;
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_SEMI:   k = KIND_SEMI;
         default:   k = KIND_INVALID;
      endcase
      return k;
   endfunction

   // token left behind by the current mode when the run ends
   function automatic pend_type flush_token(input mode_type mode, input logic [2:0] kp,
                                            input logic km, input logic [VALUE_BITS-1:0] accum,
                                            input logic ovf);
      pend_type p;
      p.valid = 1'b0;
      p.kind  = KIND_INVALID;
      p.value = '0;
      case (mode)
         MODE_WORD: begin
            p.valid = 1'b1;
            p.kind  = (!km && kp == KW_LENGTH) ? KIND_PRINT : KIND_INVALID;
         end
         MODE_NUM: begin
            p.valid = 1'b1;
            if (!ovf) begin
               p.kind  = KIND_NUMBER;
               p.value = accum;
            end
         end
         MODE_SLASH: begin
            p.valid = 1'b1;
            p.kind  = KIND_SLASH;
         end
         default: p.valid = 1'b0;
      endcase
      return p;
   endfunction

endpackage

@@ src/elt_scan.sv @@
// scanner state and per-byte token generation
module elt_scan import elt_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] ch,
   input  logic       fin,
   output bundle_type bundle
);

   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   mode_type                 mode_ff, mode_in;
   logic [VALUE_BITS-1:0]    accum_ff, accum_in;
   logic                     ovf_ff, ovf_in;
   logic [2:0]               kp_ff, kp_in;
   logic                     km_ff, km_in;
   logic [POSITION_BITS-1:0] cur_line_ff, cur_line_in;
   logic [POSITION_BITS-1:0] cur_col_ff, cur_col_in;
   logic [POSITION_BITS-1:0] st_line_ff, st_line_in;
   logic [POSITION_BITS-1:0] st_col_ff, st_col_in;

   // state after the byte, before end of text is applied
   mode_type                 mid_mode;
   logic [VALUE_BITS-1:0]    mid_accum;
   logic                     mid_ovf;
   logic [2:0]               mid_kp;
   logic                     mid_km;
   logic [POSITION_BITS-1:0] mid_st_line, mid_st_col;
   logic [POSITION_BITS-1:0] nxt_line, nxt_col;

   logic       c_alpha, c_digit, c_space, c_nl, c_slash, c_zero;
   logic       call_idle, op_emit, do_reset, active;
   logic [34:0] prod;
   pend_type   old_pend, mid_pend;
   token_type  [3:0] cand;
   logic       [3:0] cand_valid;
   logic       [1:0] cnt;

   // saturated position to output width
   function automatic logic [POS_OUT_BITS-1:0] clamp_pos(input logic [POSITION_BITS-1:0] p);
      logic [32:0] w;
      w = 33'(p);
      return (w > 33'h0_FFFF) ? '1 : w[POS_OUT_BITS-1:0];
   endfunction

   assign c_alpha = is_alpha(ch);
   assign c_digit = is_digit(ch);
   assign c_space = is_space(ch);
   assign c_nl    = ch == CH_NL;
   assign c_slash = ch == CH_SLASH;
   assign c_zero  = ch == CH_NUL;
   assign active  = mode_ff != MODE_DONE;
   assign prod    = 35'(accum_ff) * 35'd10 + 35'(ch - CH_ZERO);

   // mode handling and start of new runs
   always_comb begin
      mid_mode    = mode_ff;
      mid_accum   = accum_ff;
      mid_ovf     = ovf_ff;
      mid_kp      = kp_ff;
      mid_km      = km_ff;
      mid_st_line = st_line_ff;
      mid_st_col  = st_col_ff;
      call_idle   = 1'b0;
      op_emit     = 1'b0;
      case (mode_ff)
         MODE_WORD: begin
            if (c_alpha || c_digit) begin
               if (!km_ff && kp_ff < KW_LENGTH && ch == kw_char(kp_ff)) begin
                  mid_kp = kp_ff + 3'd1;
               end else begin
                  mid_km = 1'b1;
               end
            end else begin
               call_idle = 1'b1;
            end
         end
         MODE_NUM: begin
            if (c_digit) begin
               if (prod > VALUE_MAX) begin
                  mid_ovf   = 1'b1;
                  mid_accum = '0;
               end else begin
                  mid_accum = prod[VALUE_BITS-1:0];
               end
            end else begin
               call_idle = 1'b1;
            end
         end
         MODE_SLASH: begin
            if (c_slash) mid_mode = MODE_COMMENT;
            else call_idle = 1'b1;
         end
         MODE_COMMENT: begin
            if (c_nl) mid_mode = MODE_IDLE;
         end
         default: call_idle = 1'b1;
      endcase
      if (call_idle) begin
         mid_mode = MODE_IDLE;
         if (c_space) begin
            mid_mode = MODE_IDLE;
         end else if (c_slash || c_alpha || c_digit) begin
            mid_st_line = cur_line_ff;
            mid_st_col  = cur_col_ff;
            if (c_slash) begin
               mid_mode = MODE_SLASH;
            end else if (c_alpha) begin
               mid_mode = MODE_WORD;
               mid_kp   = (ch == kw_char(3'd0)) ? 3'd1 : 3'd0;
               mid_km   = ch != kw_char(3'd0);
            end else begin
               mid_mode  = MODE_NUM;
               mid_accum = VALUE_BITS'(ch - CH_ZERO);
               mid_ovf   = 1'b0;
            end
         end else begin
            op_emit = 1'b1;
         end
      end
   end

   // position after the byte
   always_comb begin
      nxt_line = cur_line_ff;
      nxt_col  = cur_col_ff;
      if (!c_zero) begin
         if (c_nl) begin
            if (cur_line_ff != POS_MAX) nxt_line = cur_line_ff + POS_ONE;
            nxt_col = POS_ONE;
         end else if (cur_col_ff != POS_MAX) begin
            nxt_col = cur_col_ff + POS_ONE;
         end
      end
   end

   assign old_pend = flush_token(mode_ff, kp_ff, km_ff, accum_ff, ovf_ff);
   assign mid_pend = flush_token(mid_mode, mid_kp, mid_km, mid_accum, mid_ovf);

   // candidate tokens in emission order
   always_comb begin
      cand[0].kind   = old_pend.kind;
      cand[0].value  = old_pend.value;
      cand[0].line   = clamp_pos(st_line_ff);
      cand[0].column = clamp_pos(st_col_ff);
      cand_valid[0]  = active && old_pend.valid && (c_zero || call_idle);

      cand[1].kind   = op_kind(ch);
      cand[1].value  = '0;
      cand[1].line   = clamp_pos(cur_line_ff);
      cand[1].column = clamp_pos(cur_col_ff);
      cand_valid[1]  = active && !c_zero && op_emit;

      cand[2].kind   = mid_pend.kind;
      cand[2].value  = mid_pend.value;
      cand[2].line   = clamp_pos(mid_st_line);
      cand[2].column = clamp_pos(mid_st_col);
      cand_valid[2]  = active && !c_zero && fin && mid_pend.valid;

      cand[3].kind   = KIND_END;
      cand[3].value  = '0;
      cand[3].line   = clamp_pos(nxt_line);
      cand[3].column = clamp_pos(nxt_col);
      cand_valid[3]  = active && (c_zero || fin);
   end

   // pack valid candidates into the bundle
   always_comb begin
      bundle.slot = '0;
      cnt = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (cand_valid[i] && cnt != 2'(MAX_TOKENS)) begin
            bundle.slot[cnt] = cand[i];
            cnt = cnt + 2'd1;
         end
      end
      bundle.count = cnt;
   end

   // next state of the scanner
   assign do_reset = fin;
   always_comb begin
      mode_in     = mode_ff;
      accum_in    = accum_ff;
      ovf_in      = ovf_ff;
      kp_in       = kp_ff;
      km_in       = km_ff;
      cur_line_in = cur_line_ff;
      cur_col_in  = cur_col_ff;
      st_line_in  = st_line_ff;
      st_col_in   = st_col_ff;
      if (do_reset) begin
         mode_in     = MODE_IDLE;
         accum_in    = '0;
         ovf_in      = 1'b0;
         kp_in       = 3'd0;
         km_in       = 1'b0;
         cur_line_in = POS_ONE;
         cur_col_in  = POS_ONE;
         st_line_in  = POS_ONE;
         st_col_in   = POS_ONE;
      end else if (!active) begin
         mode_in = MODE_DONE;
      end else if (c_zero) begin
         mode_in = MODE_DONE;
      end else begin
         mode_in     = mid_mode;
         accum_in    = mid_accum;
         ovf_in      = mid_ovf;
         kp_in       = mid_kp;
         km_in       = mid_km;
         cur_line_in = nxt_line;
         cur_col_in  = nxt_col;
         st_line_in  = mid_st_line;
         st_col_in   = mid_st_col;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         accum_ff    <= '0;
         ovf_ff      <= 1'b0;
         kp_ff       <= 3'd0;
         km_ff       <= 1'b0;
         cur_line_ff <= POS_ONE;
         cur_col_ff  <= POS_ONE;
         st_line_ff  <= POS_ONE;
         st_col_ff   <= POS_ONE;
      end else if (step) begin
         mode_ff     <= mode_in;
         accum_ff    <= accum_in;
         ovf_ff      <= ovf_in;
         kp_ff       <= kp_in;
         km_ff       <= km_in;
         cur_line_ff <= cur_line_in;
         cur_col_ff  <= cur_col_in;
         st_line_ff  <= st_line_in;
         st_col_ff   <= st_col_in;
      end
   end

endmodule

@@ src/elt_out.sv @@
// result register holding one byte's tokens and sending them one word at a time
module elt_out import elt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  bundle_type  bundle,
   output logic        free,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // kind[3:0], value[34:4], tok_line[50:35], tok_column[66:51]
   output logic        rsp_tlast   // run_end
);

   token_type [MAX_TOKENS-1:0] slot_ff;
   logic [1:0] cnt_ff;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       take, last;
   token_type  cur;

   assign take       = valid_ff && rsp_tready;
   assign last       = idx_ff == (cnt_ff - 2'd1);
   assign free       = !valid_ff || (take && last);
   assign cur        = slot_ff[idx_ff];
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last;
   assign rsp_tdata  = {5'd0, cur.column, cur.line, cur.value, cur.kind};

   // slot pointer and valid flag
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (take) begin
         if (last) valid_in = 1'b0;
         else idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // token payload
   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= bundle.slot;
         cnt_ff  <= bundle.count;
      end
   end

endmodule

@@ src/expression_language_tokenizer.sv @@
// expression language tokenizer: input register, scanner and result register
// path: a byte is held in the input register, then its tokens are registered in the result register
// throughput: one byte per cycle while each byte yields at most one token and rsp_tready is high;
//   a byte yielding n tokens holds the result register until all are sent, one token word per cycle
// reset: synchronous, active high; clears the scanner to idle at line 1, column 1
// a final-flagged byte returns the scanner to the same state
module expression_language_tokenizer import elt_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch[7:0]
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // kind[3:0], value[34:4], tok_line[50:35], tok_column[66:51]
   output logic        rsp_tlast    // run_end
);

   logic       in_valid_ff;
   logic [7:0] in_ch_ff;
   logic       in_fin_ff;
   logic       step, free, load;
   bundle_type bundle;

   // a byte moves on when its tokens fit in the result register
   assign step       = in_valid_ff && (free || bundle.count == 2'd0);
   assign load       = step && bundle.count != 2'd0;
   assign req_tready = !in_valid_ff || step;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff  <= req_tdata;
         in_fin_ff <= req_tlast;
      end
   end

   elt_scan #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .ch    (in_ch_ff),
      .fin   (in_fin_ff),
      .bundle(bundle)
   );

   elt_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .bundle    (bundle),
      .free      (free),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

@@ verif/tb_top.sv @@
// testbench of the expression language tokenizer: directed table, random source text, closing run
module tb_top import elt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          LIMIT_CYCLES = 700_000;
   localparam int          RANDOM_BYTES = 160;
   localparam int          TAIL_BYTES   = 40;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          KW_LEN       = 5;
   localparam logic [39:0] KEYWORD      = "print";
   localparam logic [15:0] POS_TOP      = 16'hFFFF;
   localparam logic [30:0] NUM_TOP      = 31'h7FFF_FFFF;

   // one token word as the result channel carries it
   typedef struct packed {
      kind_type    kind;
      logic [30:0] value;
      logic [15:0] line;
      logic [15:0] column;
      logic        run_end;
   } token_word_t;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } src_byte_t;

   // directed row: typed rows carry their single expected token
   typedef struct packed {
      logic [7:0]  ch;
      logic        last;
      logic        typed;
      kind_type    kind;
      logic [30:0] value;
      logic [15:0] line;
      logic [15:0] column;
   } table_row_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;  // ch[7:0]
   logic        req_tlast  = 1'b0;   // final_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;           // kind[3:0], value[34:4], tok_line[50:35], tok_column[66:51]
   logic        rsp_tlast;           // run_end

   expression_language_tokenizer #(.POSITION_BITS(16)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scanner copy
   mode_type    scan_state;
   logic [30:0] acc_value;
   logic        acc_ovf;
   logic [2:0]  kw_hits;
   logic        kw_broken;
   logic [15:0] pos_line, pos_col, tok_line0, tok_col0;

   token_word_t step_tokens[$];
   token_word_t expected_tokens[$];
   src_byte_t   source_text[$];

   int  mismatch_count = 0;
   int  tokens_checked = 0;
   int  bytes_sent     = 0;
   int  texts_closed   = 0;
   int  cycle_count    = 0;
   bit  idling_on      = 1'b1;
   bit  tx_calm        = 1'b0;
   bit  rx_calm        = 1'b0;
   int  rx_stall       = 0;

   // directed stimulus: operators, extremes, held slash, comment, keyword, end-of-text cases
   table_row_t directed_rows [25] = '{
      '{CH_PLUS,   1'b0, 1'b1, KIND_PLUS,    31'd0, 16'd1, 16'd1},
      '{CH_MINUS,  1'b0, 1'b1, KIND_MINUS,   31'd0, 16'd1, 16'd2},
      '{CH_STAR,   1'b0, 1'b1, KIND_STAR,    31'd0, 16'd1, 16'd3},
      '{CH_LPAREN, 1'b0, 1'b1, KIND_LPAREN,  31'd0, 16'd1, 16'd4},
      '{CH_RPAREN, 1'b0, 1'b1, KIND_RPAREN,  31'd0, 16'd1, 16'd5},
      '{CH_SEMI,   1'b0, 1'b1, KIND_SEMI,    31'd0, 16'd1, 16'd6},
      '{8'hFF,     1'b0, 1'b1, KIND_INVALID, 31'd0, 16'd1, 16'd7},
      '{CH_SLASH,  1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{CH_PLUS,   1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{CH_SLASH,  1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{CH_SLASH,  1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{8'h80,     1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{CH_NL,     1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{"p",       1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{"r",       1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{"i",       1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{"n",       1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{"t",       1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{CH_SPACE,  1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{"9",       1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{CH_TAB,    1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{CH_NUL,    1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{"a",       1'b0, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{CH_PLUS,   1'b1, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0},
      '{"7",       1'b1, 1'b0, KIND_END,     31'd0, 16'd0, 16'd0}
   };

   // character classes
   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_num_char(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   task automatic clear_scanner();
      scan_state = MODE_IDLE;
      acc_value  = '0;
      acc_ovf    = 1'b0;
      kw_hits    = '0;
      kw_broken  = 1'b0;
      pos_line   = 16'd1;
      pos_col    = 16'd1;
      tok_line0  = 16'd1;
      tok_col0   = 16'd1;
   endtask

   // at most three tokens leave per byte
   task automatic push_token(input kind_type k, input logic [30:0] v,
                             input logic [15:0] l, input logic [15:0] c);
      token_word_t t;
      if (step_tokens.size() < 3) begin
         t.kind    = k;
         t.value   = v;
         t.line    = l;
         t.column  = c;
         t.run_end = 1'b0;
         step_tokens.insert(step_tokens.size(), t);
      end
   endtask

   // pending word, number or held slash turns into its token
   task automatic close_token();
      kind_type k;
      case (scan_state)
         MODE_WORD: begin
            k = (!kw_broken && kw_hits == 3'(KW_LEN)) ? KIND_PRINT : KIND_INVALID;
            push_token(k, '0, tok_line0, tok_col0);
         end
         MODE_NUM: begin
            if (acc_ovf) push_token(KIND_INVALID, '0, tok_line0, tok_col0);
            else push_token(KIND_NUMBER, acc_value, tok_line0, tok_col0);
         end
         MODE_SLASH: push_token(KIND_SLASH, '0, tok_line0, tok_col0);
         default: ;
      endcase
      scan_state = MODE_IDLE;
   endtask

   task automatic word_letter(input logic [7:0] c);
      int idx;
      idx = int'(kw_hits);
      if (!kw_broken && idx < KW_LEN && c == KEYWORD[39 - 8*idx -: 8]) kw_hits = kw_hits + 3'd1;
      else kw_broken = 1'b1;
   endtask

   // sticky overflow above 2^31-1
   task automatic number_digit(input logic [7:0] c);
      logic [34:0] v;
      v = 35'(acc_value) * 35'd10 + 35'(c) - 35'(CH_ZERO);
      if (v > 35'(NUM_TOP)) begin
         acc_ovf = 1'b1;
         v = '0;
      end
      acc_value = v[30:0];
   endtask

   // byte seen with nothing pending
   task automatic fresh_char(input logic [7:0] c);
      kind_type k;
      scan_state = MODE_IDLE;
      if (!is_blank(c)) begin
         case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_SEMI:   k = KIND_SEMI;
            default:   k = KIND_INVALID;
         endcase
         if (c == CH_SLASH || is_letter(c) || is_num_char(c)) begin
            tok_line0 = pos_line;
            tok_col0  = pos_col;
            if (c == CH_SLASH) begin
               scan_state = MODE_SLASH;
            end else if (is_letter(c)) begin
               scan_state = MODE_WORD;
               kw_hits    = '0;
               kw_broken  = 1'b0;
               word_letter(c);
            end else begin
               scan_state = MODE_NUM;
               acc_value  = '0;
               acc_ovf    = 1'b0;
               number_digit(c);
            end
         end else begin
            push_token(k, '0, pos_line, pos_col);
         end
      end
   endtask

   // tokens caused by one accepted byte, queued when keep is set
   task automatic predict_byte(input logic [7:0] c, input logic last, input logic keep);
      step_tokens.delete();
      if (scan_state == MODE_DONE) begin
         if (last) clear_scanner();
      end else if (c == CH_NUL) begin
         close_token();
         push_token(KIND_END, '0, pos_line, pos_col);
         if (last) clear_scanner();
         else scan_state = MODE_DONE;
      end else begin
         case (scan_state)
            MODE_WORD: begin
               if (is_letter(c) || is_num_char(c)) word_letter(c);
               else begin
                  close_token();
                  fresh_char(c);
               end
            end
            MODE_NUM: begin
               if (is_num_char(c)) number_digit(c);
               else begin
                  close_token();
                  fresh_char(c);
               end
            end
            MODE_SLASH: begin
               if (c == CH_SLASH) scan_state = MODE_COMMENT;
               else begin
                  close_token();
                  fresh_char(c);
               end
            end
            MODE_COMMENT: begin
               if (c == CH_NL) scan_state = MODE_IDLE;
            end
            default: fresh_char(c);
         endcase
         // saturating position
         if (c == CH_NL) begin
            if (pos_line != POS_TOP) pos_line = pos_line + 16'd1;
            pos_col = 16'd1;
         end else if (pos_col != POS_TOP) begin
            pos_col = pos_col + 16'd1;
         end
         if (last) begin
            close_token();
            push_token(KIND_END, '0, pos_line, pos_col);
            clear_scanner();
         end
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].run_end = 1'b1;
      if (keep) begin
         foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
      end
   endtask

   // one word on the input channel, then maybe an idle burst
   task automatic send_byte(input logic [7:0] c, input logic last,
                            input logic use_typed, input token_word_t typed_tok);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(c, last, !use_typed);
      if (use_typed) expected_tokens.insert(expected_tokens.size(), typed_tok);
      bytes_sent++;
      if (last) texts_closed++;
      if (idling_on && !tx_calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
   endtask

   task automatic send_text();
      foreach (source_text[i]) send_byte(source_text[i].ch, source_text[i].last, 1'b0, '0);
      source_text.delete();
   endtask

   task automatic add_char(input logic [7:0] c, input logic last);
      source_text.insert(source_text.size(), src_byte_t'{c, last});
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i], 1'b0);
   endtask

   // random piece of source text, mostly well-formed tokens
   task automatic add_piece();
      string letters;
      string alnum;
      string ops;
      string blanks;
      int    pick;
      int    n;
      letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
      alnum   = {letters, "0123456789"};
      ops     = "+-*/();";
      blanks  = " \011\012\013\014\015";
      pick    = $urandom_range(0, 99);
      if (pick < 12) begin
         add_text("print");
      end else if (pick < 18) begin
         case ($urandom_range(0, 3))
            0: add_text("prin");
            1: add_text("printf");
            2: add_text("Print");
            default: add_text("pr1nt");
         endcase
      end else if (pick < 28) begin
         add_char(letters[$urandom_range(0, letters.len() - 1)], 1'b0);
         n = $urandom_range(0, 6);
         repeat (n) add_char(alnum[$urandom_range(0, alnum.len() - 1)], 1'b0);
      end else if (pick < 38) begin
         n = $urandom_range(1, 3);
         repeat (n) add_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
      end else if (pick < 44) begin
         // numbers around the overflow limit
         case ($urandom_range(0, 3))
            0: add_text("2147483647");
            1: add_text("2147483648");
            2: begin
               add_char(8'(CH_ZERO + $urandom_range(1, 2)), 1'b0);
               repeat (9) add_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
            end
            default: begin
               n = $urandom_range(11, 14);
               repeat (n) add_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
            end
         endcase
      end else if (pick < 64) begin
         add_char(ops[$urandom_range(0, ops.len() - 1)], 1'b0);
      end else if (pick < 74) begin
         add_char(blanks[$urandom_range(0, blanks.len() - 1)], 1'b0);
      end else if (pick < 80) begin
         add_text("//");
         n = $urandom_range(0, 5);
         repeat (n) add_char(8'($urandom_range(1, 255)), 1'b0);
         add_char(CH_NL, 1'b0);
      end else if (pick < 88) begin
         add_char(8'($urandom_range(1, 255)), 1'b0);
      end else if (pick < 93) begin
         // zero byte, ignored junk, then the closing final byte
         add_char(CH_NUL, 1'b0);
         n = $urandom_range(0, 3);
         repeat (n) add_char(8'($urandom_range(0, 255)), 1'b0);
         add_char(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         add_char(($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(1, 255)), 1'b1);
      end
      if ($urandom_range(0, 1) == 0) add_char(CH_SPACE, 1'b0);
   endtask

   task automatic report_mismatch(input string what, input logic [71:0] got,
                                  input logic [71:0] want);
      $display("MISMATCH %s: got 'h%0h, expected 'h%0h (token %0d)",
               what, got, want, tokens_checked);
      mismatch_count++;
   endtask

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d tokens outstanding",
                  cycle_count, expected_tokens.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result channel: compare each token word, then stall bursts on ready
   always @(posedge clock) begin : collect
      token_word_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tokens.size() == 0) begin
            report_mismatch("token with nothing expected", rsp_tdata, '0);
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_tdata[3:0] != want.kind) report_mismatch("kind", rsp_tdata[3:0], want.kind);
            if (rsp_tdata[34:4] != want.value)
               report_mismatch("value", rsp_tdata[34:4], want.value);
            if (rsp_tdata[50:35] != want.line)
               report_mismatch("line", rsp_tdata[50:35], want.line);
            if (rsp_tdata[66:51] != want.column)
               report_mismatch("column", rsp_tdata[66:51], want.column);
            if (rsp_tdata[71:67] != '0) report_mismatch("padding", rsp_tdata[71:67], '0);
            if (rsp_tlast != want.run_end) report_mismatch("run end", rsp_tlast, want.run_end);
            tokens_checked++;
         end
      end
      if (rx_stall > 0) begin
         rsp_tready <= 1'b0;
         rx_stall = rx_stall - 1;
      end else if (idling_on && !rx_calm && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         rx_stall = $urandom_range(1, 19) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
   end

   initial begin : stimulus
      token_word_t typed_tok;
      clear_scanner();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         typed_tok = '{directed_rows[i].kind, directed_rows[i].value, directed_rows[i].line,
                       directed_rows[i].column, 1'b1};
         send_byte(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed, typed_tok);
      end
      // sender holds off until the block has drained
      wait_drained();

      // random source text with idling on both sides
      while (source_text.size() < RANDOM_BYTES) add_piece();
      add_char(CH_SEMI, 1'b1);
      send_text();
      wait_drained();

      // last part without idling: keyword after an operator, number limit and overflow
      idling_on = 1'b0;
      add_text("+print");
      add_char(CH_NL, 1'b0);
      add_text("2147483647;214748364");
      add_char("8", 1'b1);
      while (source_text.size() < TAIL_BYTES) add_piece();
      add_char(CH_NUL, 1'b1);
      send_text();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d bytes in %0d texts, checked %0d tokens, %0d mismatches",
               bytes_sent, texts_closed, tokens_checked, mismatch_count);
      $display("covered operators, keyword, number limit and overflow, comments, held slash,");
      $display("end of text, ignored bytes after a zero byte, stalls and back-to-back words");
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
